// File: hw/rtl/apjb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apjb_pkg: shared types and constants of the audio playout jitter buffer
// Word layouts, operation codes, ring sizing and the front-to-back command.
// ----------------------------------------------------------------------------
package apjb_pkg;

	localparam int RING_DEPTH = 4096;
	localparam int MAX_FRAME  = 64;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int QUEUE_DEPTH = 2;

	localparam logic [31:0] TRIM_MAX = 32'h7fff_ffff;
	localparam logic [31:0] RING_DEPTH_W = 32'(RING_DEPTH);
	localparam logic [6:0]  MAX_FRAME_W  = 7'(MAX_FRAME);

	localparam logic [2:0] OP_PUSH    = 3'd0;
	localparam logic [2:0] OP_CONSUME = 3'd1;
	localparam logic [2:0] OP_FLUSH   = 3'd2;
	localparam logic [2:0] OP_DROP    = 3'd3;
	localparam logic [2:0] OP_TRIM    = 3'd4;
	localparam logic [2:0] OP_GATE    = 3'd5;

	typedef struct packed {
		logic [2:0]         operation;
		logic signed [15:0] sample_in;
		logic [31:0]        amount;
		logic [6:0]         frame_length;
		logic               gate_open;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic               last;
		logic [15:0]        peak;
		logic               underrun;
		logic [31:0]        discarded;
		logic               accepted;
		logic [31:0]        dropped_total;
		logic [31:0]        underrun_total;
	} out_word_t;

	// classified command handed from front to back
	typedef struct packed {
		logic [2:0]         operation;
		logic signed [15:0] sample_in;
		logic [31:0]        amount;
		logic [6:0]         frame_length;
		logic               gate_open;
	} cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/apjb_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apjb_front: input stage and command queue
// Accepts words, clamps amount and frame length, and queues them for the back.
// ----------------------------------------------------------------------------
module apjb_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  apjb_pkg::in_word_t  in_word,
	output logic                cmd_valid,
	input  wire                 cmd_ready,
	output apjb_pkg::cmd_t      cmd
);
	import apjb_pkg::*;

	cmd_t      q_mem_q [QUEUE_DEPTH];
	logic      wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	cmd_t      cls;
	logic      push, pop;

	// classify: clamp amount and frame length
	always_comb begin
		cls.operation = in_word.operation;
		cls.sample_in = in_word.sample_in;
		cls.amount = (in_word.amount > TRIM_MAX) ? TRIM_MAX : in_word.amount;
		if (in_word.frame_length == 7'd0)
			cls.frame_length = 7'd1;
		else if (in_word.frame_length > MAX_FRAME_W)
			cls.frame_length = MAX_FRAME_W;
		else
			cls.frame_length = in_word.frame_length;
		cls.gate_open = in_word.gate_open;
	end

	assign in_ready  = (count_q != 2'(QUEUE_DEPTH));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= cls;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/apjb_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apjb_back: ring control and playout sequencer
// Executes one command at a time; an open-gate consume plans its reads, trim
// discard and underrun, streams ring words and pads with zeros; a gated one gives zeros.
// ----------------------------------------------------------------------------
module apjb_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cmd_valid,
	output logic                 cmd_ready,
	input  apjb_pkg::cmd_t       cmd,
	output logic                 out_valid,
	input  wire                  out_ready,
	output apjb_pkg::out_word_t  out_word
);
	import apjb_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PLAN  = 6'b000010,
		ST_FETCH = 6'b000100,
		ST_CAP   = 6'b001000,
		ST_PAD   = 6'b010000,
		ST_DROP  = 6'b100000
	} state_t;

	logic [15:0] ring_q [RING_DEPTH];

	state_t      state_q;
	logic [31:0] rd_pos_q, wr_pos_q;
	logic        trim_pend_q, gate_q;
	logic [31:0] trim_start_q;
	logic [30:0] trim_len_q;
	logic [31:0] dropped_q, underrun_cnt_q, frames_q;
	logic [15:0] peak_run_q;

	cmd_t        cur_q;
	logic [6:0]  idx_q;     // words emitted so far
	logic [6:0]  got_q;     // samples planned for playout
	logic        seg2_q;    // first read segment recorded
	logic [6:0]  cnt1_q;    // samples in first segment
	logic [31:0] base2_q;   // ring position of second segment
	logic [31:0] fetch_q;   // ring position of next sample to play
	logic        und_q;
	logic [31:0] gone_q;
	logic [15:0] peak_q;
	logic [15:0] rdata_q;
	logic        out_v_q;
	out_word_t   out_q;

	logic [31:0] fill, ahead, span_gap, left, disc, amt_lim, want_w, lim, rd_cnt;
	logic [6:0]  want, got_nxt;
	logic [15:0] smp, mag, peak_nxt;
	logic        room, take, out_free, fire, lst, reach;
	out_word_t   nxt_word;

	assign fill     = wr_pos_q - rd_pos_q;
	assign ahead    = rd_pos_q - trim_start_q;
	assign span_gap = trim_start_q - rd_pos_q;
	assign left     = trim_start_q + {1'b0, trim_len_q} - rd_pos_q;
	assign want     = cur_q.frame_length - got_q;
	assign want_w   = 32'(want);
	assign amt_lim  = (cur_q.operation == OP_DROP) ? cur_q.amount : left;
	assign disc     = (amt_lim > fill) ? fill : amt_lim;
	// read limit of one pass: the frame remainder or the span start, then the ring level
	assign lim      = (trim_pend_q && ahead[31] && span_gap < want_w) ? span_gap : want_w;
	assign rd_cnt   = (lim > fill) ? fill : lim;
	assign got_nxt  = got_q + rd_cnt[6:0];
	assign reach    = trim_pend_q && ahead[31] && (span_gap < want_w) && (fill >= span_gap);
	assign smp      = rdata_q;
	assign mag      = smp[15] ? (16'd0 - smp) : smp;
	assign peak_nxt = (mag > peak_q) ? mag : peak_q;
	assign lst      = (idx_q + 7'd1 == cur_q.frame_length);

	assign room      = (fill < RING_DEPTH_W);
	assign cmd_ready = (state_q == ST_IDLE) && !out_v_q;
	assign take      = cmd_valid && cmd_ready;
	assign out_free  = !out_v_q || out_ready;
	assign out_valid = out_v_q;
	assign out_word  = out_q;

	// sample ring: one write on push, one registered read for playout
	always_ff @(posedge clk) begin
		if (take && cmd.operation == OP_PUSH && room)
			ring_q[wr_pos_q[RING_AW-1:0]] <= cmd.sample_in;
		rdata_q <= ring_q[fetch_q[RING_AW-1:0]];
	end

	// next output word
	always_comb begin
		nxt_word = '0;
		nxt_word.dropped_total = dropped_q;
		nxt_word.underrun_total = underrun_cnt_q;
		fire = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (take && cmd.operation != OP_CONSUME && cmd.operation != OP_DROP) begin
					fire = 1'b1;
					nxt_word.last = 1'b1;
					nxt_word.accepted = (cmd.operation == OP_PUSH) && room;
				end
			end
			ST_DROP: begin
				fire = out_free;
				nxt_word.last = 1'b1;
				nxt_word.discarded = disc;
				nxt_word.dropped_total = dropped_q + disc;
			end
			ST_CAP: begin
				fire = out_free;
				nxt_word.sample_out = smp;
				if (lst) begin
					nxt_word.last = 1'b1;
					nxt_word.peak = peak_nxt;
					nxt_word.underrun = und_q;
					nxt_word.discarded = gone_q;
				end
			end
			ST_PAD: begin
				fire = out_free;
				if (lst) begin
					nxt_word.last = 1'b1;
					nxt_word.peak = peak_q;
					nxt_word.underrun = und_q;
					nxt_word.discarded = gone_q;
				end
			end
			default: fire = 1'b0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			out_q <= '0;
		end else if (fire) begin
			out_v_q <= 1'b1;
			out_q <= nxt_word;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_pos_q <= '0; wr_pos_q <= '0;
			trim_pend_q <= 1'b0; trim_start_q <= '0; trim_len_q <= '0;
			gate_q <= 1'b0;
			dropped_q <= '0; underrun_cnt_q <= '0; frames_q <= '0;
			peak_run_q <= '0;
			cur_q <= '0;
			idx_q <= '0; got_q <= '0; seg2_q <= 1'b0; cnt1_q <= '0;
			base2_q <= '0; fetch_q <= '0;
			und_q <= 1'b0; gone_q <= '0; peak_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						cur_q <= cmd;
						unique case (cmd.operation)
							OP_PUSH: begin
								if (room) wr_pos_q <= wr_pos_q + 32'd1;
							end
							OP_CONSUME: begin
								frames_q <= frames_q + 32'(cmd.frame_length);
								idx_q <= '0; got_q <= '0; seg2_q <= 1'b0; cnt1_q <= '0;
								und_q <= 1'b0; gone_q <= '0; peak_q <= '0;
								state_q <= gate_q ? ST_PLAN : ST_PAD;
							end
							OP_FLUSH: rd_pos_q <= wr_pos_q;
							OP_DROP: state_q <= ST_DROP;
							OP_TRIM: begin
								if (cmd.amount != 32'd0) begin
									trim_start_q <= wr_pos_q - cmd.amount;
									trim_len_q <= cmd.amount[30:0];
									trim_pend_q <= 1'b1;
								end
							end
							OP_GATE: gate_q <= cmd.gate_open;
							default: ;
						endcase
					end
				end
				ST_DROP: begin
					// discard up to the buffered level
					if (out_free) begin
						rd_pos_q <= rd_pos_q + disc;
						dropped_q <= dropped_q + disc;
						state_q <= ST_IDLE;
					end
				end
				ST_PLAN: begin
					if (trim_pend_q && !ahead[31]) begin
						// at or past the span: discard the rest, up to the ring level, and clear the request
						if (left != 32'd0 && !left[31]) begin
							rd_pos_q <= rd_pos_q + disc;
							dropped_q <= dropped_q + disc;
							gone_q <= gone_q + disc;
						end
						trim_pend_q <= 1'b0;
					end else begin
						// one read segment, up to the span, the ring level or frame end
						rd_pos_q <= rd_pos_q + rd_cnt;
						got_q <= got_nxt;
						if (!seg2_q) begin
							cnt1_q <= rd_cnt[6:0];
							fetch_q <= rd_pos_q;
							seg2_q <= 1'b1;
						end else begin
							base2_q <= rd_pos_q;
						end
						if (!reach) begin
							if (got_nxt != cur_q.frame_length) begin
								und_q <= 1'b1;
								underrun_cnt_q <= underrun_cnt_q + 32'd1;
							end
							state_q <= (got_nxt != 7'd0) ? ST_FETCH : ST_PAD;
						end
					end
				end
				ST_FETCH: begin
					// ring read of fetch_q lands in rdata_q
					state_q <= ST_CAP;
				end
				ST_CAP: begin
					if (out_free) begin
						peak_q <= peak_nxt;
						idx_q <= idx_q + 7'd1;
						if (lst) begin
							peak_run_q <= peak_nxt;
							state_q <= ST_IDLE;
						end else if (idx_q + 7'd1 < got_q) begin
							fetch_q <= (idx_q + 7'd1 == cnt1_q) ? base2_q : fetch_q + 32'd1;
							state_q <= ST_FETCH;
						end else begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					// padding or gated zeros
					if (out_free) begin
						idx_q <= idx_q + 7'd1;
						if (lst) begin
							peak_run_q <= peak_q;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/audio_playout_jitter_buffer_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// audio_playout_jitter_buffer_unit: 16-bit audio jitter buffer with playout
// Input words carry push, consume, flush, drop, trim and gate operations.
// Output words carry played samples and status; the last word of an
// operation is flagged by last.
// A word passes the two-entry command queue. Push, flush, trim, gate
// and unused codes give their word through the output register after the
// queue, a drop through the drop state and then the output register. The
// back takes a new command only with the output register empty, so it
// does not start one while the last word waits. A consume plans its reads,
// trim discard and underrun in the plan state, then plays each ring sample
// through fetch (ring read) and capture (output), each padded or gated zero through pad.
// Reset clears positions, counters, trim and gate (closed); the sample
// ring itself is not cleared. If the receiver stalls, the output register
// holds its word and the back stops; the front queue keeps accepting
// until full.
// ----------------------------------------------------------------------------
module audio_playout_jitter_buffer_unit (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  apjb_pkg::in_word_t   in_word,
	output logic                 out_valid,
	input  wire                  out_ready,
	output apjb_pkg::out_word_t  out_word
);
	import apjb_pkg::*;

	cmd_t cmd;
	logic cmd_valid, cmd_ready;

	apjb_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_word,
		.cmd_valid, .cmd_ready, .cmd
	);

	apjb_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.out_valid, .out_ready, .out_word
	);

endmodule
`default_nettype wire

// File: hw/rtl/apjb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apjb_checker: port-level checks of the jitter buffer
// Output protocol and status field consistency.
// ----------------------------------------------------------------------------
module apjb_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 out_valid,
	input wire                 out_ready,
	input apjb_pkg::out_word_t out_word
);
	import apjb_pkg::*;

	// stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	// peak only on last
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.last |-> out_word.peak == 16'd0)
		else $error("peak outside last word");

	// peak never above full scale
	a_peak_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.peak <= 16'd32768)
		else $error("peak out of range");

endmodule

bind audio_playout_jitter_buffer_unit apjb_checker u_checker (
	.clk, .arst_n, .out_valid, .out_ready, .out_word
);
`default_nettype wire
